// File: rtl/sst_pkg.sv
package sst_pkg;

   // Widths fixed by the item fields
   localparam int KeyWidth  = 32;
   localparam int PosWidth  = 6;
   localparam int SizeWidth = 7;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_ERASE  = 2'd1,
      OP_FIND   = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_DUPLICATE = 2'd1,
      ST_FULL      = 2'd2,
      ST_MISS      = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_CMP,
      FSM_EXEC
   } fsm_type;

   // Command broadcast from the controller to every cell
   typedef struct packed {
      logic                        ins_en;
      logic                        del_en;
      logic signed [KeyWidth-1:0]  key;
   } cmd_type;

endpackage

// File: rtl/sst_req_if.sv
interface sst_req_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          req_type;
   logic signed [sst_pkg::KeyWidth-1:0] key_value;
   logic [sst_pkg::PosWidth-1:0]        position_in;

   modport source (output valid, req_type, key_value, position_in, input ready);
   modport sink (input valid, req_type, key_value, position_in, output ready);
endinterface

// File: rtl/sst_rsp_if.sv
interface sst_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          status;
   logic                                found;
   logic [sst_pkg::PosWidth-1:0]        position_out;
   logic signed [sst_pkg::KeyWidth-1:0] entry_value;
   logic [sst_pkg::SizeWidth-1:0]       set_size;

   modport source (output valid, status, found, position_out, entry_value, set_size,
                   input ready);
   modport sink (input valid, status, found, position_out, entry_value, set_size,
                 output ready);
endinterface

// File: rtl/sorted_unique_set_table.sv
// Channel   Port      Direction  Payload
// request   req_chan  in         req_type, key_value, position_in
// response  rsp_chan  out        status, found, position_out, entry_value, set_size
//
// Each item first registers the compare flags of every cell in FSM_CMP,
// then shifts the row and loads the response register in FSM_EXEC.
// A new item is taken in the same cycle the previous one finishes.
// Reset clears the state, the entry count and the response valid flag; cell contents stay undefined.
// A stalled response holds the item in its final cycle until the slot frees.
module sorted_unique_set_table #(
   parameter int CAPACITY = 64
) (
   input  logic clock,
   input  logic reset,
   sst_req_if.sink   req_chan,
   sst_rsp_if.source rsp_chan
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int PW = (CW > sst_pkg::PosWidth) ? CW : sst_pkg::PosWidth;

   sst_pkg::fsm_type                    state_ff, state_in;
   logic [CW-1:0]                       count_ff, count_in;
   logic [1:0]                          op_ff;
   logic signed [sst_pkg::KeyWidth-1:0] key_ff;
   logic [sst_pkg::PosWidth-1:0]        pos_ff;

   logic                                rsp_valid_ff, rsp_valid_in;
   sst_pkg::status_type                 rsp_status_ff, rsp_status_in;
   logic                                rsp_found_ff, rsp_found_in;
   logic [sst_pkg::PosWidth-1:0]        rsp_pos_ff, rsp_pos_in;
   logic signed [sst_pkg::KeyWidth-1:0] rsp_value_ff, rsp_value_in;
   logic [sst_pkg::SizeWidth-1:0]       rsp_size_ff, rsp_size_in;

   logic                                req_fire;
   logic                                exec_fire;
   logic                                dup;
   logic                                full;
   logic                                bad_pos;
   logic [IW-1:0]                       eq_pos;
   logic [IW-1:0]                       bnd_pos;
   logic signed [sst_pkg::KeyWidth-1:0] del_value;
   logic [PW-1:0]                       pos_ext;
   sst_pkg::cmd_type                    cmd;

   logic                                lt_w    [CAPACITY];
   logic                                eq_w    [CAPACITY];
   logic                                hit_w   [CAPACITY];
   logic signed [sst_pkg::KeyWidth-1:0] value_w [CAPACITY];

   assign req_fire  = req_chan.valid && req_chan.ready;
   assign exec_fire = (state_ff == sst_pkg::FSM_EXEC) && (!rsp_valid_ff || rsp_chan.ready);
   assign pos_ext   = PW'(pos_ff);

   // Row of cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                                left_lt;
      logic signed [sst_pkg::KeyWidth-1:0] left_value;
      logic signed [sst_pkg::KeyWidth-1:0] right_value;

      if (i == 0) begin : g_first
         assign left_lt    = 1'b1;
         assign left_value = cmd.key;
      end else begin : g_mid
         assign left_lt    = lt_w[i-1];
         assign left_value = value_w[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_value = value_w[i];
      end else begin : g_inner
         assign right_value = value_w[i+1];
      end

      sst_cell #(
         .INDEX (i),
         .CW    (CW),
         .PW    (PW)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .count       (count_ff),
         .pos_ext     (pos_ext),
         .left_lt     (left_lt),
         .left_value  (left_value),
         .right_value (right_value),
         .lt_ff       (lt_w[i]),
         .eq_ff       (eq_w[i]),
         .hit_ff      (hit_w[i]),
         .value_ff    (value_w[i])
      );
   end

   // Encode the match, the insert boundary and the erased value
   always_comb begin
      dup       = 1'b0;
      eq_pos    = '0;
      bnd_pos   = '0;
      del_value = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (eq_w[i]) begin
            dup    = 1'b1;
            eq_pos = eq_pos | IW'(i);
         end
         if (!lt_w[i] && ((i == 0) || lt_w[(i == 0) ? 0 : i - 1])) begin
            bnd_pos = bnd_pos | IW'(i);
         end
         if (hit_w[i]) begin
            del_value = del_value | value_w[i];
         end
      end
   end

   assign full    = count_ff == CW'(CAPACITY);
   assign bad_pos = pos_ext >= PW'(count_ff);

   // Next state, cell command and response
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      cmd.key       = key_ff;
      cmd.ins_en    = 1'b0;
      cmd.del_en    = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_size_in   = rsp_size_ff;
      req_chan.ready = (state_ff == sst_pkg::FSM_IDLE) || exec_fire;

      case (state_ff)
         sst_pkg::FSM_IDLE: begin
            if (req_fire) state_in = sst_pkg::FSM_CMP;
         end
         sst_pkg::FSM_CMP: begin
            state_in = sst_pkg::FSM_EXEC;
         end
         sst_pkg::FSM_EXEC: begin
            if (exec_fire) begin
               state_in      = req_fire ? sst_pkg::FSM_CMP : sst_pkg::FSM_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = sst_pkg::ST_MISS;
               rsp_found_in  = 1'b0;
               rsp_pos_in    = '0;
               rsp_value_in  = '0;
               case (op_ff)
                  sst_pkg::OP_INSERT: begin
                     rsp_value_in = key_ff;
                     if (dup) begin
                        rsp_status_in = sst_pkg::ST_DUPLICATE;
                        rsp_found_in  = 1'b1;
                        rsp_pos_in    = sst_pkg::PosWidth'(eq_pos);
                     end else if (full) begin
                        rsp_status_in = sst_pkg::ST_FULL;
                     end else begin
                        rsp_status_in = sst_pkg::ST_OK;
                        rsp_pos_in    = sst_pkg::PosWidth'(bnd_pos);
                        cmd.ins_en    = 1'b1;
                        count_in      = count_ff + CW'(1);
                     end
                  end
                  sst_pkg::OP_ERASE: begin
                     if (!bad_pos) begin
                        rsp_status_in = sst_pkg::ST_OK;
                        rsp_pos_in    = pos_ff;
                        rsp_value_in  = del_value;
                        cmd.del_en    = 1'b1;
                        count_in      = count_ff - CW'(1);
                     end
                  end
                  sst_pkg::OP_FIND: begin
                     if (dup) begin
                        rsp_status_in = sst_pkg::ST_OK;
                        rsp_found_in  = 1'b1;
                        rsp_pos_in    = sst_pkg::PosWidth'(eq_pos);
                        rsp_value_in  = key_ff;
                     end
                  end
                  default: begin
                     rsp_status_in = sst_pkg::ST_MISS;
                  end
               endcase
               rsp_size_in = sst_pkg::SizeWidth'(count_in);
            end
         end
         default: begin
            state_in = sst_pkg::FSM_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sst_pkg::FSM_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the accepted item and the response payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff  <= req_chan.req_type;
         key_ff <= req_chan.key_value;
         pos_ff <= req_chan.position_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_size_ff   <= rsp_size_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.found        = rsp_found_ff;
   assign rsp_chan.position_out = rsp_pos_ff;
   assign rsp_chan.entry_value  = rsp_value_ff;
   assign rsp_chan.set_size     = rsp_size_ff;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_accept_to_cmp: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == sst_pkg::FSM_CMP)
      else $error("accepted item did not enter compare");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.ins_en |=> count_ff == CW'($past(count_ff) + CW'(1)))
      else $error("insert did not grow the set");

   a_no_both: assert property (@(posedge clock) disable iff (reset)
      !(cmd.ins_en && cmd.del_en))
      else $error("insert and erase issued together");

endmodule

// File: rtl/sst_cell.sv
module sst_cell #(
   parameter int INDEX = 0,
   parameter int CW    = 7,
   parameter int PW    = 7
) (
   input  logic                                clock,
   input  sst_pkg::cmd_type                    cmd,
   input  logic [CW-1:0]                       count,
   input  logic [PW-1:0]                       pos_ext,
   input  logic                                left_lt,
   input  logic signed [sst_pkg::KeyWidth-1:0] left_value,
   input  logic signed [sst_pkg::KeyWidth-1:0] right_value,
   output logic                                lt_ff,
   output logic                                eq_ff,
   output logic                                hit_ff,
   output logic signed [sst_pkg::KeyWidth-1:0] value_ff
);

   logic                                valid;
   logic                                lt_in;
   logic                                eq_in;
   logic                                hit_in;
   logic                                ge_in;
   logic                                ge_ff;
   logic signed [sst_pkg::KeyWidth-1:0] value_in;

   // Compare own entry against the key and own index against the position
   assign valid  = count > CW'(INDEX);
   assign lt_in  = valid && (value_ff < cmd.key);
   assign eq_in  = valid && (value_ff == cmd.key);
   assign hit_in = pos_ext == PW'(INDEX);
   assign ge_in  = PW'(INDEX) >= pos_ext;

   // Open a slot or close a gap using the neighbors
   always_comb begin
      value_in = value_ff;
      if (cmd.ins_en && !lt_ff) begin
         value_in = left_lt ? cmd.key : left_value;
      end else if (cmd.del_en && ge_ff) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      lt_ff    <= lt_in;
      eq_ff    <= eq_in;
      hit_ff   <= hit_in;
      ge_ff    <= ge_in;
      value_ff <= value_in;
   end

endmodule
